// ===== hdl/kcl_pkg.sv =====
// Shared types, codes and the keypad decode table for the keypad code lock.
package kcl_pkg;

   localparam int CODE_DIGITS_DEFAULT = 6;

   localparam int PASSWORD_WIDTH = 24;
   localparam int LIMIT_WIDTH    = 4;
   localparam int KEY_WIDTH      = 5;
   localparam int DIGITS_WIDTH   = 24;
   localparam int COUNT_WIDTH    = 3;
   localparam int WRONG_WIDTH    = 4;

   localparam logic [PASSWORD_WIDTH-1:0] PASSWORD_RESET    = 24'h123789;
   localparam logic [LIMIT_WIDTH-1:0]    ERROR_LIMIT_RESET = 4'd3;
   localparam logic [WRONG_WIDTH-1:0]    WRONG_MAX         = 4'd15;

   // register indexes on the csr port
   localparam logic CSR_PASSWORD    = 1'b0;
   localparam logic CSR_ERROR_LIMIT = 1'b1;

   // raw scan codes with a function of their own
   localparam logic [KEY_WIDTH-1:0] SCAN_ENTER  = 5'd12;
   localparam logic [KEY_WIDTH-1:0] SCAN_CLEAR  = 5'd14;
   localparam logic [KEY_WIDTH-1:0] SCAN_CLOSE  = 5'd15;
   localparam logic [KEY_WIDTH-1:0] SCAN_NO_KEY = 5'd16;

   typedef enum logic [1:0] {
      MODE_ENTRY  = 2'd0,
      MODE_OPEN   = 2'd1,
      MODE_LOCKED = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_DIGIT   = 3'd1,
      EV_CLEARED = 3'd2,
      EV_OPENED  = 3'd3,
      EV_WRONG   = 3'd4,
      EV_LOCKOUT = 3'd5,
      EV_CLOSED  = 3'd6
   } event_type;

   typedef enum logic [2:0] {
      KEY_NONE,
      KEY_DIGIT,
      KEY_ENTER,
      KEY_CLEAR,
      KEY_CLOSE
   } key_kind_type;

   typedef struct packed {
      key_kind_type kind;
      logic [3:0]   digit;
   } key_type;

   typedef struct packed {
      logic [1:0]              lock_mode;
      logic [2:0]              event_code;
      logic [DIGITS_WIDTH-1:0] entered_digits;
      logic [COUNT_WIDTH-1:0]  entered_count;
      logic [WRONG_WIDTH-1:0]  wrong_count;
   } rsp_type;

   // 4x4 keypad layout: 1 2 3 x / 4 5 6 x / 7 8 9 x / enter 0 clear close
   function automatic key_type decode_key(input logic [KEY_WIDTH-1:0] code);
      key_type k;
      k.kind  = KEY_DIGIT;
      k.digit = 4'd0;
      case (code)
         5'd0:       k.digit = 4'd1;
         5'd1:       k.digit = 4'd2;
         5'd2:       k.digit = 4'd3;
         5'd4:       k.digit = 4'd4;
         5'd5:       k.digit = 4'd5;
         5'd6:       k.digit = 4'd6;
         5'd8:       k.digit = 4'd7;
         5'd9:       k.digit = 4'd8;
         5'd10:      k.digit = 4'd9;
         5'd13:      k.digit = 4'd0;
         SCAN_ENTER: k.kind  = KEY_ENTER;
         SCAN_CLEAR: k.kind  = KEY_CLEAR;
         SCAN_CLOSE: k.kind  = KEY_CLOSE;
         default:    k.kind  = KEY_NONE;
      endcase
      return k;
   endfunction

endpackage

// ===== hdl/kcl_step.sv =====
// Next-state and result logic for one scanned key word of the code lock.
module kcl_step
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEFAULT,
   localparam int EW = 4 * CODE_DIGITS,
   localparam int CW = $clog2(CODE_DIGITS + 1)
) (
   input  logic [KEY_WIDTH-1:0]      key_code,
   input  logic [KEY_WIDTH-1:0]      prev_key,
   input  mode_type                  mode,
   input  logic [EW-1:0]             entry,
   input  logic [CW-1:0]             count,
   input  logic [WRONG_WIDTH-1:0]    errors,
   input  logic [PASSWORD_WIDTH-1:0] password,
   input  logic [LIMIT_WIDTH-1:0]    error_limit,
   output logic [KEY_WIDTH-1:0]      prev_key_next,
   output mode_type                  mode_next,
   output logic [EW-1:0]             entry_next,
   output logic [CW-1:0]             count_next,
   output logic [WRONG_WIDTH-1:0]    errors_next,
   output rsp_type                   rsp
);

   key_type                          key;
   logic [EW-1:0]                    entry_ins;
   logic [EW+PASSWORD_WIDTH-1:0]     pw_wide;
   logic [EW+DIGITS_WIDTH-1:0]       digits_wide;
   logic [CW+COUNT_WIDTH-1:0]        count_wide;
   logic [WRONG_WIDTH-1:0]           errors_inc;
   logic                             full;
   logic                             same;
   event_type                        ev;

   // a repeat of the previous scan is a held key
   assign key = (key_code != prev_key) ? decode_key(key_code) :
                key_type'{kind: KEY_NONE, digit: 4'd0};
   assign prev_key_next = key_code;

   assign pw_wide    = {{EW{1'b0}}, password};
   assign full       = (count == CW'(CODE_DIGITS));
   assign same       = (entry == pw_wide[EW-1:0]);
   assign errors_inc = (errors != WRONG_MAX) ? errors + 4'd1 : errors;

   // first digit lands in the top nibble
   always_comb begin
      for (int i = 0; i < CODE_DIGITS; i++) begin
         entry_ins[4*i +: 4] = entry[4*i +: 4] |
            ((count == CW'(CODE_DIGITS - 1 - i)) ? key.digit : 4'd0);
      end
   end

   always_comb begin
      mode_next   = mode;
      entry_next  = entry;
      count_next  = count;
      errors_next = errors;
      ev          = EV_NONE;
      case (mode)
         MODE_ENTRY: begin
            case (key.kind)
               KEY_DIGIT: begin
                  if (count < CW'(CODE_DIGITS)) begin
                     entry_next = entry_ins;
                     count_next = count + CW'(1);
                     ev         = EV_DIGIT;
                  end
               end
               KEY_ENTER: begin
                  entry_next = '0;
                  count_next = '0;
                  if (full && same) begin
                     mode_next   = MODE_OPEN;
                     errors_next = '0;
                     ev          = EV_OPENED;
                  end else begin
                     errors_next = errors_inc;
                     if (errors_inc >= error_limit) begin
                        mode_next = MODE_LOCKED;
                        ev        = EV_LOCKOUT;
                     end else begin
                        ev = EV_WRONG;
                     end
                  end
               end
               KEY_CLEAR: begin
                  entry_next = '0;
                  count_next = '0;
                  ev         = EV_CLEARED;
               end
               default: ;
            endcase
         end
         MODE_OPEN: begin
            if (key.kind == KEY_CLOSE) begin
               mode_next = MODE_ENTRY;
               ev        = EV_CLOSED;
            end
         end
         default: ;  // lockout holds until reset
      endcase
   end

   assign digits_wide = {{DIGITS_WIDTH{1'b0}}, entry_next};
   assign count_wide  = {{COUNT_WIDTH{1'b0}}, count_next};

   assign rsp.lock_mode      = mode_next;
   assign rsp.event_code     = ev;
   assign rsp.entered_digits = digits_wide[DIGITS_WIDTH-1:0];
   assign rsp.entered_count  = count_wide[COUNT_WIDTH-1:0];
   assign rsp.wrong_count    = errors_next;

endmodule

// ===== hdl/keypad_code_lock.sv =====
// Keypad code lock: one result word per scanned key, one word per cycle while
// req_stall is low. The lock state updates as the key word is taken, and each
// result is registered into a two-word output stage (result register plus skid),
// so req_stall rises only when both words are waiting on rsp_stall.
// csr writes take effect on the next key word and belong only to idle periods.
module keypad_code_lock
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [KEY_WIDTH-1:0]      req_key_code,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_lock_mode,
   output logic [2:0]                rsp_event_code,
   output logic [DIGITS_WIDTH-1:0]   rsp_entered_digits,
   output logic [COUNT_WIDTH-1:0]    rsp_entered_count,
   output logic [WRONG_WIDTH-1:0]    rsp_wrong_count,
   input  logic                      csr_write,
   input  logic                      csr_index,
   input  logic [PASSWORD_WIDTH-1:0] csr_data
);

   localparam int EW = 4 * CODE_DIGITS;
   localparam int CW = $clog2(CODE_DIGITS + 1);

   logic [PASSWORD_WIDTH-1:0] password_ff;
   logic [LIMIT_WIDTH-1:0]    error_limit_ff;

   logic [KEY_WIDTH-1:0]      prev_key_ff, prev_key_in;
   mode_type                  mode_ff, mode_in;
   logic [EW-1:0]             entry_ff, entry_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [WRONG_WIDTH-1:0]    errors_ff, errors_in;

   rsp_type                   result;
   rsp_type                   out_ff;
   rsp_type                   skid_ff;
   logic                      out_valid_ff;
   logic                      skid_valid_ff;

   logic                      req_take;
   logic                      out_take;

   kcl_step #(
      .CODE_DIGITS(CODE_DIGITS)
   ) u_step (
      .key_code     (req_key_code),
      .prev_key     (prev_key_ff),
      .mode         (mode_ff),
      .entry        (entry_ff),
      .count        (count_ff),
      .errors       (errors_ff),
      .password     (password_ff),
      .error_limit  (error_limit_ff),
      .prev_key_next(prev_key_in),
      .mode_next    (mode_in),
      .entry_next   (entry_in),
      .count_next   (count_in),
      .errors_next  (errors_in),
      .rsp          (result)
   );

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !req_stall;
   assign out_take  = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         password_ff    <= PASSWORD_RESET;
         error_limit_ff <= ERROR_LIMIT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PASSWORD:    password_ff    <= csr_data;
            CSR_ERROR_LIMIT: error_limit_ff <= csr_data[LIMIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_key_ff <= SCAN_NO_KEY;
         mode_ff     <= MODE_ENTRY;
         entry_ff    <= '0;
         count_ff    <= '0;
         errors_ff   <= '0;
      end else if (req_take) begin
         prev_key_ff <= prev_key_in;
         mode_ff     <= mode_in;
         entry_ff    <= entry_in;
         count_ff    <= count_in;
         errors_ff   <= errors_in;
      end
   end

   // output register with skid; a new word only parks in the skid when the
   // output word is still waiting
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (req_take) begin
            if (out_valid_ff && !out_take) begin
               skid_valid_ff <= 1'b1;
            end else begin
               out_valid_ff <= 1'b1;
            end
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_ff <= skid_ff;
         end
      end else if (req_take) begin
         if (out_valid_ff && !out_take) begin
            skid_ff <= result;
         end else begin
            out_ff <= result;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_lock_mode      = out_ff.lock_mode;
   assign rsp_event_code     = out_ff.event_code;
   assign rsp_entered_digits = out_ff.entered_digits;
   assign rsp_entered_count  = out_ff.entered_count;
   assign rsp_wrong_count    = out_ff.wrong_count;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held without an output word");

   a_park_in_skid: assert property (@(posedge clock) disable iff (reset)
      (req_take && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("word accepted under a stalled output was not parked");

   a_lockout_sticks: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_LOCKED) |=> (mode_ff == MODE_LOCKED))
      else $error("lockout left without reset");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CODE_DIGITS))
      else $error("entry count beyond code length");

   a_open_clears_errors: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.event_code == EV_OPENED) |->
         (out_ff.wrong_count == '0 && out_ff.lock_mode == MODE_OPEN))
      else $error("opened word with stale error count or mode");

endmodule
